@@ hw/rtl/microsecond_timer_with_compare_macros.svh @@
// assertion macros shared by the checker
`ifndef MICROSECOND_TIMER_WITH_COMPARE_MACROS_SVH
`define MICROSECOND_TIMER_WITH_COMPARE_MACROS_SVH

// antecedent and consequent in the same cycle
`define MTIMER_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer check failed in the same cycle");

// consequent in the cycle after the antecedent
`define MTIMER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer check failed one cycle later");

`endif

@@ hw/rtl/mtimer_pkg.sv @@
package mtimer_pkg;

    localparam int COUNTER_BITS_DEF  = 16;
    localparam int PRESCALE_BITS_DEF = 8;

    localparam logic [7:0]  PRESCALE_DIV_RESET = 8'd47;
    localparam logic [15:0] MIN_DELAY_RESET    = 16'd10;
    localparam logic [15:0] STEAL_LOW_RESET    = 16'd500;
    localparam logic [15:0] STEAL_HIGH_RESET   = 16'd10000;
    localparam logic [31:0] COMPARE_RESET      = 32'd5000;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRESCALE_DIV = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DELAY    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEAL_LOW    = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEAL_HIGH   = 2'd3;

    typedef enum logic [2:0] {
        FUNC_TICK    = 3'd0,
        FUNC_ARM     = 3'd1,
        FUNC_FORWARD = 3'd2,
        FUNC_STEAL   = 3'd3,
        FUNC_READ    = 3'd4
    } func_t;

    typedef struct packed {
        logic                      we;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_wr_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [30:0] forward_us;
        logic        with_callback;
        logic [15:0] delay;
    } item_t;

    // first member is the top bits, so now_us sits lowest
    typedef struct packed {
        logic        callback_pending;
        logic [15:0] steal_remaining;
        logic        steal_granted;
        logic        fired;
        logic [63:0] now_us;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int S_DATA_BITS = 48;
    localparam int M_DATA_BITS = 88;

endpackage

@@ hw/rtl/microsecond_timer_with_compare.sv @@
// channel   dir  tdata                                   tuser
// s_        in   delay, with_callback, forward_us        func
// m_        out  now_us, fired, steal_granted,           -
//                steal_remaining, callback_pending
// cfg_      in   write enable, index, 16-bit data        -
//
// one item per cycle while s_tready is high; its result is registered into the output buffer
// the update is a single pass through the timer core, one 64-bit add on the time sum
// a two-entry output buffer keeps s_tready high while one result waits on m_tready
// s_tready drops only while both output entries are full
// rst_n clears the timer state and loads the register defaults at once
module microsecond_timer_with_compare #(
    parameter int COUNTER_BITS  = mtimer_pkg::COUNTER_BITS_DEF,
    parameter int PRESCALE_BITS = mtimer_pkg::PRESCALE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] delay, [16] with_callback, [47:17] forward_us
    input  logic [mtimer_pkg::S_DATA_BITS-1:0]     s_tdata,
    // [2:0] func
    input  logic [2:0]                             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [63:0] now_us, [64] fired, [65] steal_granted, [81:66] steal_remaining,
    // [82] callback_pending, [87:83] zero
    output logic [mtimer_pkg::M_DATA_BITS-1:0]     m_tdata,
    input  logic                                   cfg_we,
    input  logic [mtimer_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mtimer_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    mtimer_pkg::cfg_wr_t cfg;
    mtimer_pkg::item_t   item;
    mtimer_pkg::result_t result;
    mtimer_pkg::result_t out_reg;
    mtimer_pkg::result_t skid_reg;
    logic                out_valid_reg;
    logic                skid_valid_reg;
    logic                in_xfer;
    logic                out_xfer;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign item.func          = s_tuser;
    assign item.delay         = s_tdata[15:0];
    assign item.with_callback = s_tdata[16];
    assign item.forward_us    = s_tdata[47:17];

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;

    mtimer_core #(
        .COUNTER_BITS  (COUNTER_BITS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (in_xfer),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_xfer)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(mtimer_pkg::M_DATA_BITS - mtimer_pkg::RESULT_BITS)'(0), out_reg};

endmodule

@@ hw/rtl/mtimer_core.sv @@
module mtimer_core #(
    parameter int COUNTER_BITS  = mtimer_pkg::COUNTER_BITS_DEF,
    parameter int PRESCALE_BITS = mtimer_pkg::PRESCALE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mtimer_pkg::cfg_wr_t cfg,
    input  logic                accept,
    input  mtimer_pkg::item_t   item,
    output mtimer_pkg::result_t result
);

    localparam int RW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    logic [7:0]               prescale_div_reg;
    logic [15:0]              min_delay_reg;
    logic [15:0]              steal_low_reg;
    logic [15:0]              steal_high_reg;

    logic [PRESCALE_BITS-1:0] prescale_count_reg, prescale_count_next;
    logic [COUNTER_BITS-1:0]  tick_counter_reg, tick_counter_next;
    logic [COUNTER_BITS-1:0]  compare_value_reg, compare_value_next;
    logic                     pending_reg, pending_next;
    // holds offset plus counter; a counter wrap adds 2^COUNTER_BITS and drops the
    // counter to zero, so every tick is a plain increment of this sum
    logic [63:0]              now_reg, now_next;

    logic [PRESCALE_BITS-1:0] div;
    logic [COUNTER_BITS-1:0]  tick_inc;
    logic [15:0]              delay_clamped;
    logic [COUNTER_BITS-1:0]  remaining;
    logic [RW-1:0]            remaining_wide;
    logic [63:0]              now_add;
    logic                     fired;
    logic                     granted;
    logic [15:0]              steal_rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_div_reg <= mtimer_pkg::PRESCALE_DIV_RESET;
            min_delay_reg    <= mtimer_pkg::MIN_DELAY_RESET;
            steal_low_reg    <= mtimer_pkg::STEAL_LOW_RESET;
            steal_high_reg   <= mtimer_pkg::STEAL_HIGH_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                mtimer_pkg::CFG_PRESCALE_DIV: prescale_div_reg <= cfg.data[7:0];
                mtimer_pkg::CFG_MIN_DELAY:    min_delay_reg    <= cfg.data;
                mtimer_pkg::CFG_STEAL_LOW:    steal_low_reg    <= cfg.data;
                mtimer_pkg::CFG_STEAL_HIGH:   steal_high_reg   <= cfg.data;
                default:                      ;
            endcase
        end
    end

    assign div            = PRESCALE_BITS'(prescale_div_reg);
    assign tick_inc       = tick_counter_reg + COUNTER_BITS'(1);
    assign delay_clamped  = (item.delay < min_delay_reg) ? min_delay_reg : item.delay;
    assign remaining      = compare_value_reg - tick_counter_reg;
    assign remaining_wide = RW'(remaining);

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        tick_counter_next   = tick_counter_reg;
        compare_value_next  = compare_value_reg;
        pending_next        = pending_reg;
        now_add             = 64'd0;
        fired               = 1'b0;
        granted             = 1'b0;
        steal_rem           = 16'd0;

        case (mtimer_pkg::func_t'(item.func))
            mtimer_pkg::FUNC_TICK:
            begin
                if (prescale_count_reg >= div)
                begin
                    prescale_count_next = '0;
                    tick_counter_next   = tick_inc;
                    now_add             = 64'd1;
                    if (tick_inc == compare_value_reg)
                    begin
                        fired        = pending_reg;
                        pending_next = 1'b0;
                    end
                end
                else
                begin
                    prescale_count_next = prescale_count_reg + PRESCALE_BITS'(1);
                end
            end
            mtimer_pkg::FUNC_ARM:
            begin
                pending_next       = item.with_callback;
                compare_value_next = tick_counter_reg + COUNTER_BITS'(delay_clamped);
            end
            mtimer_pkg::FUNC_FORWARD:
            begin
                now_add = 64'(item.forward_us);
            end
            mtimer_pkg::FUNC_STEAL:
            begin
                if (pending_reg)
                begin
                    steal_rem = 16'(remaining);
                    if ((RW'(steal_low_reg) <= remaining_wide) &&
                        (remaining_wide <= RW'(steal_high_reg)))
                    begin
                        pending_next = 1'b0;
                        granted      = 1'b1;
                    end
                end
            end
            default: ;
        endcase

        now_next = now_reg + now_add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            tick_counter_reg   <= '0;
            compare_value_reg  <= COUNTER_BITS'(mtimer_pkg::COMPARE_RESET);
            pending_reg        <= 1'b0;
            now_reg            <= 64'd0;
        end
        else if (accept)
        begin
            prescale_count_reg <= prescale_count_next;
            tick_counter_reg   <= tick_counter_next;
            compare_value_reg  <= compare_value_next;
            pending_reg        <= pending_next;
            now_reg            <= now_next;
        end
    end

    assign result.now_us           = now_next;
    assign result.fired            = fired;
    assign result.steal_granted    = granted;
    assign result.steal_remaining  = steal_rem;
    assign result.callback_pending = pending_next;

endmodule

@@ hw/rtl/mtimer_checker.sv @@
`include "microsecond_timer_with_compare_macros.svh"

module mtimer_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [mtimer_pkg::M_DATA_BITS-1:0]    m_tdata
);

    // a stalled result holds
    `MTIMER_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // every input transfer leaves a result on the output next cycle
    `MTIMER_ASSERT_NEXT(a_in_gives_out, clk, rst_n, s_tvalid && s_tready, m_tvalid)
    // input back-pressure only while a result is waiting
    `MTIMER_ASSERT_SAME(a_ready_low, clk, rst_n, !s_tready, m_tvalid && !$past(m_tready && m_tvalid) || m_tvalid)
    // a fired callback is no longer pending, and no steal is granted with it
    `MTIMER_ASSERT_SAME(a_fired_clears, clk, rst_n, m_tvalid && m_tdata[64], !m_tdata[82] && !m_tdata[65])

endmodule

bind microsecond_timer_with_compare mtimer_checker u_mtimer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
